/* hw/rtl/csvfp_pkg.sv */
// Shared constants for the CSV field parser.
`default_nettype none

package csvfp_pkg;

	// Default field limit; the index saturates at min(MAX_FIELDS - 1, 255)
	localparam int unsigned MAX_FIELDS_DEF = 255;

	// Payload widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 8;

	// Characters with a meaning to the parser
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;

	// Flags of one result, packed into tuser with char_valid at bit 0
	typedef struct packed {
		logic parse_error;
		logic field_end;
		logic char_valid;
	} flags_t;

endpackage

`default_nettype wire

/* hw/rtl/csv_field_parser.sv */
// CSV line parser: splits a byte stream into fields, one byte per cycle unless stalled.
//
// Input stream (s_axis): one line character per request in tdata; tlast marks
// the final byte of the line buffer. A newline byte also ends the line.
// Output stream (m_axis): exactly one result per input byte. tdata carries the
// character after quote removal and the field index; tuser carries the
// char_valid, field_end and parse_error flags; tlast marks the line end.
//
// Path: a byte accepted on s_axis passes the input stage and then the output
// register (two registers) before it appears on m_axis.
// Throughput: one byte per cycle while m_axis_tready holds; the parse state is a
// small register, so bytes stream back to back.
// When the receiver stalls, the output register holds its request and the
// input stage fills; s_axis_tready drops only once both are occupied.
// Reset clears both stages and returns the parser to the start of a field
// with the field index at zero.
`default_nettype none

module csv_field_parser #(
	parameter int unsigned MAX_FIELDS = csvfp_pkg::MAX_FIELDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tlast,   // last_byte
	// Result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] char_out, [15:8] field_index
	output logic [2:0]       m_axis_tuser,   // [0] char_valid, [1] field_end,
	                                         // [2] parse_error
	output logic             m_axis_tlast    // line_end
);

	// Saturation point of the field index
	localparam int unsigned CapInt = (MAX_FIELDS - 1 > 255) ? 255 : (MAX_FIELDS - 1);
	localparam logic [csvfp_pkg::INDEX_W-1:0] IdxCap = csvfp_pkg::INDEX_W'(CapInt);

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_QUOTED = 3'd1,
		PH_PLAIN  = 3'd2,
		PH_QSEEN  = 3'd3,
		PH_SKIP   = 3'd4
	} phase_t;

	// Input stage
	logic                            valid_s1;
	logic [csvfp_pkg::BYTE_W-1:0]    byte_s1;
	logic                            last_s1;

	// Parse state
	phase_t                          phase_q;
	logic [csvfp_pkg::INDEX_W-1:0]   counter_q;

	// Output register
	logic                            out_valid_q;
	logic [csvfp_pkg::BYTE_W-1:0]    char_q;
	logic [csvfp_pkg::INDEX_W-1:0]   index_q;
	csvfp_pkg::flags_t               flags_q;
	logic                            line_end_q;

	// Next-state and result logic
	phase_t                          phase_d;
	logic [csvfp_pkg::INDEX_W-1:0]   counter_d;
	logic [csvfp_pkg::BYTE_W-1:0]    char_d;
	logic [csvfp_pkg::INDEX_W-1:0]   index_d;
	csvfp_pkg::flags_t               flags_d;
	logic                            line_end_d;
	logic                            close_field;
	logic                            advance;

	// Move the input stage on whenever the output register is free or drains
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Parse one byte against the current phase
	always_comb begin
		phase_d     = phase_q;
		counter_d   = counter_q;
		char_d      = '0;
		index_d     = counter_q;
		flags_d     = '0;
		line_end_d  = 1'b0;
		close_field = 1'b0;
		if (phase_q == PH_SKIP) begin
			if (byte_s1 == csvfp_pkg::CH_NL || last_s1) begin
				line_end_d = 1'b1;
				phase_d    = PH_START;
				counter_d  = '0;
			end
		end else if (byte_s1 == csvfp_pkg::CH_NL) begin
			flags_d.field_end = 1'b1;
			line_end_d        = 1'b1;
			phase_d           = PH_START;
			counter_d         = '0;
		end else begin
			case (phase_q)
				PH_QUOTED: begin
					if (byte_s1 == csvfp_pkg::CH_QUOTE) begin
						phase_d = PH_QSEEN;
					end else begin
						flags_d.char_valid = 1'b1;
						char_d             = byte_s1;
					end
				end
				PH_PLAIN: begin
					if (byte_s1 == csvfp_pkg::CH_COMMA) begin
						close_field = 1'b1;
					end else begin
						flags_d.char_valid = 1'b1;
						char_d             = byte_s1;
					end
				end
				PH_QSEEN: begin
					if (byte_s1 == csvfp_pkg::CH_QUOTE) begin
						flags_d.char_valid = 1'b1;
						char_d             = byte_s1;
						phase_d            = PH_QUOTED;
					end else if (byte_s1 == csvfp_pkg::CH_COMMA) begin
						close_field = 1'b1;
					end else begin
						flags_d.parse_error = 1'b1;
						phase_d             = PH_SKIP;
					end
				end
				default: begin
					if (byte_s1 == csvfp_pkg::CH_QUOTE) begin
						phase_d = PH_QUOTED;
					end else if (byte_s1 == csvfp_pkg::CH_COMMA) begin
						close_field = 1'b1;
					end else begin
						flags_d.char_valid = 1'b1;
						char_d             = byte_s1;
						phase_d            = PH_PLAIN;
					end
				end
			endcase
			// Close the field and bump the saturating index
			if (close_field) begin
				flags_d.field_end = 1'b1;
				counter_d         = (counter_q < IdxCap) ? counter_q + 1'b1 : IdxCap;
				phase_d           = PH_START;
			end
			// Last byte closes the final field unless it was a stray character
			if (last_s1) begin
				line_end_d = 1'b1;
				if (!flags_d.parse_error) begin
					flags_d.field_end = 1'b1;
					index_d           = counter_d;
				end
				phase_d   = PH_START;
				counter_d = '0;
			end
		end
	end

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
			last_s1  <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			byte_s1  <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
		end
	end

	// Parse state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			index_q     <= '0;
			flags_q     <= '0;
			line_end_q  <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_d;
				counter_q   <= counter_d;
				out_valid_q <= 1'b1;
				char_q      <= char_d;
				index_q     <= index_d;
				flags_q     <= flags_d;
				line_end_q  <= line_end_d;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {index_q, char_q};
	assign m_axis_tuser  = flags_q;
	assign m_axis_tlast  = line_end_q;

	// A stray character neither carries data nor closes a field
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && flags_q.parse_error |-> !flags_q.char_valid && !flags_q.field_end)
		else $error("parse_error together with data or field end");

	// No data character means a zero character
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !flags_q.char_valid |-> char_q == '0)
		else $error("char_out not zero without char_valid");

	// The field index never passes its saturation point
	assert property (@(posedge clk) disable iff (!arst_n)
		counter_q <= IdxCap && (!out_valid_q || index_q <= IdxCap))
		else $error("field index beyond its limit");

	// A line end restarts parsing at the first field
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && line_end_d |=> phase_q == PH_START && counter_q == '0)
		else $error("parser not restarted after line end");

	// The skip phase only follows a parse error
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_d == PH_SKIP && phase_q != PH_SKIP |-> flags_d.parse_error)
		else $error("skip phase entered without a parse error");

endmodule

`default_nettype wire
